FILE: sv/ltsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsc_pkg: shared types and constants of the tile slot cache
// Field widths, register indexes, reset values and state encodings.
// ----------------------------------------------------------------------------
package ltsc_pkg;

    localparam int SIG_W      = 64;
    localparam int COLS_W     = 7;
    localparam int ROWS_W     = 7;
    localparam int TILE_W     = 9;
    localparam int POS_W      = 14;
    localparam int SLOT_OUT_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int MAX_SLOTS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd3;

    localparam logic [COLS_W-1:0] COLUMNS_RST     = 7'd8;
    localparam logic [ROWS_W-1:0] ROWS_RST        = 7'd8;
    localparam logic [TILE_W-1:0] TILE_WIDTH_RST  = 9'd64;
    localparam logic [TILE_W-1:0] TILE_HEIGHT_RST = 9'd64;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } ltsc_state_t;

    typedef enum logic [1:0] {
        POS_IDLE,
        POS_DIV,
        POS_MUL
    } ltsc_pos_state_t;

    // Control broadcast to every cell of the recency chain
    typedef struct packed {
        logic load;
        logic hit;
    } ltsc_cell_ctrl_t;

    // Outcome flags of one lookup, handed to the position unit
    typedef struct packed {
        logic hit;
        logic evicted;
    } ltsc_flags_t;

endpackage

FILE: sv/ltsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsc_cell: one position of the recency chain
// Holds a signature and its slot, compares against the key, and shifts in
// the neighbour's entry while the chain is open at this position.
// ----------------------------------------------------------------------------
module ltsc_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 6,
    parameter int FILL_W = 7
) (
    input  logic                        aclk,
    input  ltsc_pkg::ltsc_cell_ctrl_t   ctrl,
    input  logic [ltsc_pkg::SIG_W-1:0]  key,
    input  logic [FILL_W-1:0]           fill,
    input  logic [FILL_W-1:0]           upto,
    input  logic [ltsc_pkg::SIG_W-1:0]  prev_sig,
    input  logic [SLOT_W-1:0]           prev_slot,
    input  logic                        open_in,
    input  logic [SLOT_W-1:0]           sel_in,
    output logic [ltsc_pkg::SIG_W-1:0]  sig,
    output logic [SLOT_W-1:0]           slot,
    output logic                        match,
    output logic                        open_out,
    output logic [SLOT_W-1:0]           sel_out
);
    import ltsc_pkg::*;

    logic [SIG_W-1:0]  sig_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              match_reg;
    logic              stop;

    // Only positions below the fill count take part in the compare
    always_ff @(posedge aclk) begin
        match_reg <= (FILL_W'(IDX) < fill) && (sig_reg == key);
    end

    // Shift in the neighbour's entry while the chain is open here
    always_ff @(posedge aclk) begin
        if (ctrl.load && open_in) begin
            sig_reg  <= prev_sig;
            slot_reg <= prev_slot;
        end
    end

    // The chain closes after the hit position, or after the last moved one
    assign stop     = ctrl.hit ? match_reg : (FILL_W'(IDX) == upto);
    assign open_out = open_in && !stop;
    assign sel_out  = sel_in | (stop ? slot_reg : '0);

    assign sig   = sig_reg;
    assign slot  = slot_reg;
    assign match = match_reg;

endmodule

FILE: sv/ltsc_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsc_pos: slot to pixel position unit with output register
// Splits the slot into column and row by a restoring divider, one bit a
// cycle, scales both by the tile size and holds the result word.
// ----------------------------------------------------------------------------
module ltsc_pos #(
    parameter int SLOT_W = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    input  ltsc_pkg::ltsc_flags_t             job_flags,
    input  logic [SLOT_W-1:0]                 job_slot,
    input  logic [ltsc_pkg::COLS_W-1:0]       columns,
    input  logic [ltsc_pkg::TILE_W-1:0]       tile_width,
    input  logic [ltsc_pkg::TILE_W-1:0]       tile_height,
    output logic                              job_ready,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_evicted,
    output logic [ltsc_pkg::SLOT_OUT_W-1:0]   m_slot_index,
    output logic [ltsc_pkg::POS_W-1:0]        m_atlas_x,
    output logic [ltsc_pkg::POS_W-1:0]        m_atlas_y
);
    import ltsc_pkg::*;

    localparam int CNT_W = $clog2(SLOT_W + 1);
    localparam int PX_W  = COLS_W + TILE_W;
    localparam int PY_W  = SLOT_W + TILE_W;

    ltsc_pos_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [COLS_W-1:0] rem_reg;
    logic [SLOT_W-1:0] quo_reg;
    logic [SLOT_W-1:0] slot_reg;
    ltsc_flags_t       flags_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    logic                  out_evicted_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [POS_W-1:0]      out_x_reg;
    logic [POS_W-1:0]      out_y_reg;

    logic [COLS_W:0]   trial;
    logic              ge;
    logic [COLS_W-1:0] rem_step;
    logic [SLOT_W-1:0] quo_step;
    logic [PX_W-1:0]   prod_x;
    logic [PY_W-1:0]   prod_y;
    logic              out_load;

    // One restoring step: bring down the next slot bit
    assign trial    = {rem_reg, quo_reg[SLOT_W-1]};
    assign ge       = trial >= {1'b0, columns};
    assign rem_step = ge ? COLS_W'(trial - {1'b0, columns}) : COLS_W'(trial);
    assign quo_step = SLOT_W'({quo_reg, ge});

    assign prod_x = PX_W'(rem_reg) * PX_W'(tile_width);
    assign prod_y = PY_W'(quo_reg) * PY_W'(tile_height);

    assign out_load  = (state_reg == POS_MUL) && (!out_valid_reg || m_ready);
    assign job_ready = (state_reg == POS_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= POS_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            POS_IDLE: begin
                if (job_valid) begin
                    state_next = POS_DIV;
                end
            end
            POS_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = POS_MUL;
                end
            end
            POS_MUL: begin
                if (out_load) begin
                    state_next     = POS_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = POS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == POS_IDLE && job_valid) begin
            cnt_reg   <= CNT_W'(SLOT_W);
            rem_reg   <= '0;
            quo_reg   <= job_slot;
            slot_reg  <= job_slot;
            flags_reg <= job_flags;
        end else if (state_reg == POS_DIV) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    // Pixel positions are truncated to the output field
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_hit_reg     <= flags_reg.hit;
            out_evicted_reg <= flags_reg.evicted;
            out_slot_reg    <= SLOT_OUT_W'(slot_reg);
            out_x_reg       <= POS_W'(prod_x);
            out_y_reg       <= POS_W'(prod_y);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hit        = out_hit_reg;
    assign m_evicted    = out_evicted_reg;
    assign m_slot_index = out_slot_reg;
    assign m_atlas_x    = out_x_reg;
    assign m_atlas_y    = out_y_reg;

endmodule

FILE: sv/lru_tile_slot_cache_unit.sv
`timescale 1ns / 1ps
// A lookup is compared, then waits in the update state until the position unit
//   takes it; a clear gives no result word and leaves s_ready high.
// The position unit splits the slot, SLOT_W = clog2(MAX_SLOTS) bits, into column
//   and row one bit a cycle; meanwhile the next lookup can be compared.
// Reset: fill count cleared and registers back to 8, 8, 64, 64; entry storage
//   is not cleared, and the cache is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// lru_tile_slot_cache_unit: fully associative LRU cache of atlas tile slots
// A row of cells holds the entries in recency order; a lookup compares all
// cells at once, then shifts the chain by one up to the hit, free or evicted
// entry and puts the signature at the front.
// ----------------------------------------------------------------------------
module lru_tile_slot_cache_unit #(
    parameter int MAX_SLOTS = ltsc_pkg::MAX_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // lookup / clear words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [ltsc_pkg::SIG_W-1:0]        s_signature,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_evicted,
    output logic [ltsc_pkg::SLOT_OUT_W-1:0]   m_slot_index,
    output logic [ltsc_pkg::POS_W-1:0]        m_atlas_x,
    output logic [ltsc_pkg::POS_W-1:0]        m_atlas_y,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [ltsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ltsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ltsc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int FILL_W = $clog2(MAX_SLOTS + 1);
    localparam int PROD_W = COLS_W + ROWS_W;
    localparam int CMP_W  = (FILL_W > PROD_W) ? FILL_W : PROD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COLS_W-1:0] columns_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [TILE_W-1:0] tile_width_reg;
    logic [TILE_W-1:0] tile_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg     <= COLUMNS_RST;
            rows_reg        <= ROWS_RST;
            tile_width_reg  <= TILE_WIDTH_RST;
            tile_height_reg <= TILE_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COLUMNS:     columns_reg     <= cfg_data[COLS_W-1:0];
                CFG_ROWS:        rows_reg        <= cfg_data[ROWS_W-1:0];
                CFG_TILE_WIDTH:  tile_width_reg  <= cfg_data[TILE_W-1:0];
                CFG_TILE_HEIGHT: tile_height_reg <= cfg_data[TILE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A zero column or row count counts as one
    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [PROD_W-1:0] cap_prod;

    assign cols_eff = (columns_reg == '0) ? COLS_W'(1) : columns_reg;
    assign rows_eff = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
    assign cap_prod = PROD_W'(cols_eff) * PROD_W'(rows_eff);

    // ------------------------------------------------------------------
    // Control: accept, compare cycle, update cycle
    // ------------------------------------------------------------------
    ltsc_state_t state_reg, state_next;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SIG_W-1:0]  key_reg;

    logic              full;
    logic [FILL_W-1:0] upto;
    logic              hit;
    logic              pos_ready;
    logic              upd_load;
    logic [SLOT_W-1:0] new_slot;
    ltsc_cell_ctrl_t   cell_ctrl;
    ltsc_flags_t       job_flags;

    logic [MAX_SLOTS-1:0] match_vec;
    logic [MAX_SLOTS:0]   open_chain;
    logic [SLOT_W-1:0]    sel_chain [MAX_SLOTS+1];
    logic [SIG_W-1:0]     sig_arr   [MAX_SLOTS];
    logic [SLOT_W-1:0]    slot_arr  [MAX_SLOTS];

    // Full once the fill count reaches the capacity, which saturates at the
    // number of cells; a lowered capacity leaves the count where it is
    assign full = (CMP_W'(fill_reg) >= CMP_W'(cap_prod))
               || (fill_reg == FILL_W'(MAX_SLOTS));

    // Last position that moves on a miss: the free one, or the LRU entry
    assign upto = full ? (fill_reg - FILL_W'(1)) : fill_reg;

    assign hit = |match_vec;

    // Hold the update cycle until the position unit can take the job
    assign upd_load       = (state_reg == ST_UPD) && pos_ready;
    assign cell_ctrl.load = upd_load;
    assign cell_ctrl.hit  = hit;

    // Hit and eviction both reuse the slot picked up along the chain
    assign new_slot = (hit || full) ? sel_chain[MAX_SLOTS] : SLOT_W'(fill_reg);

    assign job_flags.hit     = hit;
    assign job_flags.evicted = !hit && full;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_CLEAR) begin
                        // drop every entry, no result word
                        fill_next = '0;
                    end else begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (pos_ready) begin
                    state_next = ST_IDLE;
                    if (!hit && !full) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_op == OP_LOOKUP) begin
            key_reg <= s_signature;
        end
    end

    // ------------------------------------------------------------------
    // Recency chain: position 0 is the most recently used entry
    // ------------------------------------------------------------------
    assign open_chain[0] = 1'b1;
    assign sel_chain[0]  = '0;

    for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
        logic [SIG_W-1:0]  prev_sig;
        logic [SLOT_W-1:0] prev_slot;

        if (k == 0) begin : g_head
            assign prev_sig  = key_reg;
            assign prev_slot = new_slot;
        end else begin : g_body
            assign prev_sig  = sig_arr[k-1];
            assign prev_slot = slot_arr[k-1];
        end

        ltsc_cell #(
            .IDX    (k),
            .SLOT_W (SLOT_W),
            .FILL_W (FILL_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .key       (key_reg),
            .fill      (fill_reg),
            .upto      (upto),
            .prev_sig  (prev_sig),
            .prev_slot (prev_slot),
            .open_in   (open_chain[k]),
            .sel_in    (sel_chain[k]),
            .sig       (sig_arr[k]),
            .slot      (slot_arr[k]),
            .match     (match_vec[k]),
            .open_out  (open_chain[k+1]),
            .sel_out   (sel_chain[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Slot to pixel position and result word register
    // ------------------------------------------------------------------
    ltsc_pos #(
        .SLOT_W (SLOT_W)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (upd_load),
        .job_flags    (job_flags),
        .job_slot     (new_slot),
        .columns      (cols_eff),
        .tile_width   (tile_width_reg),
        .tile_height  (tile_height_reg),
        .job_ready    (pos_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_evicted    (m_evicted),
        .m_slot_index (m_slot_index),
        .m_atlas_x    (m_atlas_x),
        .m_atlas_y    (m_atlas_y)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // valid entries hold distinct signatures, so at most one cell matches
    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_SLOTS))
        else $error("fill count beyond the number of cells");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_load && !hit && !full) |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("fill count did not advance on a miss into a free slot");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_CLEAR) |=> (fill_reg == '0))
        else $error("clear did not empty the cache");

endmodule

FILE: tb/tb_lru_tile_slot_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_tile_slot_cache_unit: self-checking bench for the tile slot cache
// Drives lookup and clear words through the valid/ready input, keeps a
// shadow LRU cache with the atlas geometry, and checks every result word
// field by field under several grid settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_lru_tile_slot_cache_unit;
    import ltsc_pkg::*;

    localparam int SLOTS        = MAX_SLOTS_DEF;
    localparam int POOL_SIZE    = 96;
    localparam int DRAIN_CYCLES = 40;        // extra idle time after the last result word
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;

    // One expected or observed result word
    typedef struct packed {
        logic                  hit;
        logic                  evicted;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [POS_W-1:0]      atlas_x;
        logic [POS_W-1:0]      atlas_y;
    } slot_result_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_op         = OP_LOOKUP;
    logic [SIG_W-1:0]      s_signature  = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_hit;
    logic                  m_evicted;
    logic [SLOT_OUT_W-1:0] m_slot_index;
    logic [POS_W-1:0]      m_atlas_x;
    logic [POS_W-1:0]      m_atlas_y;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_COLUMNS;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    lru_tile_slot_cache_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_signature  (s_signature),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_evicted    (m_evicted),
        .m_slot_index (m_slot_index),
        .m_atlas_x    (m_atlas_x),
        .m_atlas_y    (m_atlas_y),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow cache: entries in recency order, position 0 most recently used
    // ------------------------------------------------------------------------
    logic [SIG_W-1:0] shadow_sig  [SLOTS];
    int unsigned      shadow_slot [SLOTS];
    int unsigned      shadow_fill;
    int unsigned      grid_cols, grid_rows, slot_px_w, slot_px_h;

    slot_result_t     pending_slots [$];    // result words still to arrive
    logic [SIG_W-1:0] sig_pool [POOL_SIZE]; // reused signatures to provoke hits

    logic holdoff_go = 1'b0;                 // one-cycle request to start a hold-off

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_left   = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int n_checked      = 0;
    int n_hits         = 0;
    int n_evictions    = 0;
    int n_clears       = 0;
    int n_settings     = 0;

    // Zero columns or rows count as one; capacity saturates at the slot count
    function automatic int unsigned cache_capacity();
        int unsigned c, r;
        c = (grid_cols != 0) ? grid_cols : 1;
        r = (grid_rows != 0) ? grid_rows : 1;
        return (c * r > SLOTS) ? SLOTS : c * r;
    endfunction

    // Apply one accepted word to the shadow cache and queue its result word
    function automatic void predict_slot(input logic op, input logic [SIG_W-1:0] sig);
        slot_result_t want;
        int unsigned  pos, upto, slot, c, px;
        logic         found;
        if (op == OP_CLEAR) begin
            shadow_fill = 0;
            n_clears++;
            return;
        end
        want  = '0;
        found = 1'b0;
        pos   = 0;
        for (int unsigned i = 0; i < shadow_fill && !found; i++) begin
            if (shadow_sig[i] == sig) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found) begin
            slot = shadow_slot[pos];
            upto = pos;
        end else if (shadow_fill < cache_capacity()) begin
            slot = shadow_fill;
            upto = shadow_fill;
            shadow_fill++;
        end else begin
            // full (or shrunk below the fill): reuse the oldest entry's slot
            slot = shadow_slot[shadow_fill - 1];
            upto = shadow_fill - 1;
            want.evicted = 1'b1;
        end
        if (upto > SLOTS - 1)
            upto = SLOTS - 1;
        for (int unsigned k = upto; k > 0; k--) begin
            shadow_sig[k]  = shadow_sig[k - 1];
            shadow_slot[k] = shadow_slot[k - 1];
        end
        shadow_sig[0]   = sig;
        shadow_slot[0]  = slot;
        want.hit        = found;
        want.slot_index = slot[SLOT_OUT_W-1:0];
        c               = (grid_cols != 0) ? grid_cols : 1;
        px              = (slot % c) * slot_px_w;
        want.atlas_x    = px[POS_W-1:0];
        px              = (slot / c) * slot_px_h;
        want.atlas_y    = px[POS_W-1:0];
        pending_slots.push_back(want);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit and receiver
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abandon the run if the result words stop coming
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words outstanding",
                     $time, pending_slots.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stall the result side at random; on a hold-off request load the
    // count and hold the result side off entirely until it runs out
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_go) begin
            holdoff_left <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Outputs and m_ready are settled at the falling edge, so a word seen
    // here is the one taken at the next rising edge
    always @(negedge aclk) begin
        slot_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_slots.size() == 0) begin
                $display("%0t: result word with none expected, slot %0d", $time,
                         m_slot_index);
                error_count++;
            end else begin
                want = pending_slots.pop_front();
                compare_field("hit",        want.hit,        m_hit);
                compare_field("evicted",    want.evicted,    m_evicted);
                compare_field("slot_index", want.slot_index, m_slot_index);
                compare_field("atlas_x",    want.atlas_x,    m_atlas_x);
                compare_field("atlas_y",    want.atlas_y,    m_atlas_y);
                n_checked++;
                n_hits      += want.hit;
                n_evictions += want.evicted;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers; each is entered and left at a rising edge
    // ------------------------------------------------------------------------

    // Offer one word after a random idle gap and hold it until taken
    task automatic send_word(input logic op, input logic [SIG_W-1:0] sig);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_signature <= sig;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predict_slot(op, sig);
    endtask

    // Drop valid, wait for every result word and let a clear settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register; call only with the cache idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_COLUMNS:     grid_cols = val & 7'h7F;
            CFG_ROWS:        grid_rows = val & 7'h7F;
            CFG_TILE_WIDTH:  slot_px_w = val & 9'h1FF;
            CFG_TILE_HEIGHT: slot_px_h = val & 9'h1FF;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rws,
                            input int unsigned pw, input int unsigned ph);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rws);
        write_reg(CFG_TILE_WIDTH, pw);
        write_reg(CFG_TILE_HEIGHT, ph);
        n_settings++;
    endtask

    // Idling pattern by phase: none, sender-heavy, receiver-heavy, both
    task automatic set_idling(input int pattern);
        case (pattern % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset geometry: extreme signatures, a hit, then a clear that restarts
    // slot allocation from zero
    task automatic test_reset_geometry();
        set_idling(0);
        send_word(OP_LOOKUP, 64'h0);
        send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_LOOKUP, 64'h0);
        send_word(OP_CLEAR,  64'h0);
        send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        drain_results();
    endtask

    // Zero columns and rows act as a one-slot cache; zero tile size gives
    // position zero
    task automatic test_zero_registers();
        set_grid(0, 0, 0, 0);
        send_word(OP_LOOKUP, 64'h0123_4567_89AB_CDEF);
        send_word(OP_LOOKUP, 64'hFEDC_BA98_7654_3210);
        send_word(OP_LOOKUP, 64'hFEDC_BA98_7654_3210);
        drain_results();
    endtask

    // Shrink the capacity below the fill: later misses evict the oldest
    // entry and keep the fill where it is
    task automatic test_capacity_shrink();
        set_grid(2, 2, 511, 511);
        send_word(OP_CLEAR, 64'h5555_5555_5555_5555);
        for (int i = 1; i <= 4; i++)
            send_word(OP_LOOKUP, 64'hA000_0000_0000_0000 | i);
        drain_results();
        set_grid(1, 1, 511, 511);
        send_word(OP_LOOKUP, 64'hA000_0000_0000_0005);
        send_word(OP_LOOKUP, 64'hA000_0000_0000_0004);
        send_word(OP_LOOKUP, 64'hA000_0000_0000_0001);
        send_word(OP_LOOKUP, 64'hA000_0000_0000_0004);
        drain_results();
    endtask

    // Hold the result side off for a long stretch while lookups keep
    // coming, so the cache backs up and stalls its input
    task automatic test_result_holdoff();
        set_grid(8, 8, 64, 64);
        set_idling(0);
        holdoff_go <= 1'b1;
        @(posedge aclk);
        holdoff_go <= 1'b0;
        for (int i = 0; i < 24; i++)
            send_word(OP_LOOKUP, sig_pool[$urandom_range(0, 15)]);
        drain_results();
    endtask

    // Random traffic over a pool slightly larger than the capacity, so
    // hits, fills and evictions all keep happening
    task automatic test_random_traffic(input int phase, input int n_words);
        int unsigned span;
        int          roll;
        case (phase)
            0: set_grid(8, 8, 64, 64);
            1: set_grid(127, 127, 511, 511);
            2: set_grid(1, 1, 1, 1);
            3: set_grid(64, 1, 256, 256);
            4: set_grid(1, 64, 0, 300);
            default: set_grid($urandom_range(0, 12), $urandom_range(0, 12),
                              $urandom_range(0, 511), $urandom_range(0, 511));
        endcase
        set_idling(phase);
        span = cache_capacity() + cache_capacity() / 4 + 2;
        for (int i = 0; i < n_words; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_word(OP_CLEAR, {$urandom, $urandom});
            else if (roll < 8)
                send_word(OP_LOOKUP, {$urandom, $urandom});
            else
                send_word(OP_LOOKUP, sig_pool[$urandom_range(0, span - 1)]);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        shadow_fill = 0;
        grid_cols   = COLUMNS_RST;
        grid_rows   = ROWS_RST;
        slot_px_w   = TILE_WIDTH_RST;
        slot_px_h   = TILE_HEIGHT_RST;
        for (int i = 0; i < POOL_SIZE; i++)
            sig_pool[i] = {$urandom, $urandom};
        sig_pool[0] = 64'h0;
        sig_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_geometry();
        test_zero_registers();
        test_capacity_shrink();
        test_result_holdoff();
        for (int p = 0; p < 8; p++)
            test_random_traffic(p, 45);

        $display("Checked %0d lookups (%0d hits, %0d evictions) and %0d clears",
                 n_checked, n_hits, n_evictions, n_clears);
        $display("over %0d grid settings; idling none, sender-heavy, receiver-heavy,",
                 n_settings);
        $display("mixed and one long result hold-off");
        if (error_count == 0 && pending_slots.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ltsc_pkg.sv
sv/ltsc_cell.sv
sv/ltsc_pos.sv
sv/lru_tile_slot_cache_unit.sv
tb/tb_lru_tile_slot_cache_unit.sv
